// ===== hdl/pps_pkg.sv =====
// Shared types and constants for the penalized proximal step block.
// Used by every module under hdl; no dependencies.
package pps_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WIDE          = 64;
  localparam int SUM_WIDTH     = 47;
  localparam int MAG_WIDTH     = VALUE_WIDTH - 1;

  localparam logic [2:0]           KIND_RESET   = 3'd1;
  localparam logic [MAG_WIDTH-1:0] LAMBDA_RESET = 31'd65536;
  localparam logic [MAG_WIDTH-1:0] SHAPE_RESET  = 31'd196608;

  localparam logic [1:0] CFG_KIND   = 2'd0;
  localparam logic [1:0] CFG_LAMBDA = 2'd1;
  localparam logic [1:0] CFG_SHAPE  = 2'd2;

  // Largest intermediate magnitude, 2^62 - 1
  localparam logic [WIDE-1:0] LIM = (64'd1 << 62) - 64'd1;

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_L1    = 3'd1,
    K_L2    = 3'd2,
    K_ELNET = 3'd3,
    K_MCP   = 3'd4,
    K_SCAD  = 3'd5
  } kind_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] position;
    logic signed [VALUE_WIDTH-1:0] direction;
    logic        [MAG_WIDTH-1:0]   weight;
    logic signed [VALUE_WIDTH-1:0] lower_bound;
    logic signed [VALUE_WIDTH-1:0] upper_bound;
    logic        [MAG_WIDTH-1:0]   step;
    logic                          last;
  } pps_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] new_position;
    logic                          active;
    logic        [SUM_WIDTH-1:0]   penalty_sum;
    logic                          end_of_vector;
  } pps_out_t;

  typedef struct packed {
    pps_in_t              item;
    kind_t                kind;
    logic [MAG_WIDTH-1:0] lam;
    logic [MAG_WIDTH-1:0] shape;
  } pps_job_t;

endpackage

// ===== hdl/pps_mul.sv =====
// Multi-cycle 64x64 fixed-point multiplier built from one 32x32 unit.
// Depends on pps_pkg. Gives the signed, truncated, saturated product.
module pps_mul #(
  parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [pps_pkg::WIDE-1:0] a,
  input  logic [pps_pkg::WIDE-1:0] b,
  output logic                     done,
  output logic [pps_pkg::WIDE-1:0] res
);
  import pps_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t           state;
  logic [1:0]        cnt;
  logic [WIDE-1:0]   am, bm;
  logic              neg;
  logic [2*WIDE-1:0] acc;
  logic [31:0]       ai, bi;
  logic [WIDE-1:0]   pp, prod, mag;
  logic [2*WIDE-1:0] pp_sh;

  always_comb begin
    ai = cnt[0] ? am[63:32] : am[31:0];
    bi = cnt[1] ? bm[63:32] : bm[31:0];
    pp = ai * bi;
    unique case (cnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd1,
      2'd2:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    prod = acc[WIDE-1:0] >> FRAC_BITS;
    if (acc[2*WIDE-1:WIDE] != '0) begin
      mag = LIM;
    end else begin
      mag = (prod > LIM) ? LIM : prod;
    end
    res  = neg ? (WIDE'(0) - mag) : mag;
    done = (state == M_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (start) begin
            am    <= a[WIDE-1] ? (WIDE'(0) - a) : a;
            bm    <= b;
            neg   <= a[WIDE-1];
            acc   <= '0;
            cnt   <= '0;
            state <= M_RUN;
          end
        end
        M_RUN: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= M_FIN;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/pps_div.sv =====
// Radix-2 divider for quotients below one, t/u in fixed point capped at one.
// Depends on pps_pkg. Runs FRAC_BITS+2 iterations after a setup step, or none when the quotient saturates at one.
module pps_div #(
  parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [pps_pkg::WIDE-1:0] num,
  input  logic [pps_pkg::WIDE-1:0] den,
  output logic                     done,
  output logic [pps_pkg::WIDE-1:0] res
);
  import pps_pkg::*;

  localparam int NIT = FRAC_BITS + 2;
  localparam int CW  = $clog2(NIT + 1);
  localparam logic [NIT-1:0] ONE_N = NIT'(1) << FRAC_BITS;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t         state;
  logic [CW-1:0]   cnt;
  logic [WIDE-1:0] rem, low, dv, n;
  logic [NIT-1:0]  quo;
  logic [WIDE:0]   rem2;
  logic            qbit;

  always_comb begin
    // Huge divisors shift right instead of shifting the dividend left
    if ((den >> (WIDE - FRAC_BITS)) != '0) begin
      n = num;
    end else begin
      n = num << FRAC_BITS;
    end
    rem2 = {rem, low[WIDE-1]};
    qbit = (rem2 >= {1'b0, dv});
    res  = WIDE'(quo);
    done = (state == D_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            cnt <= '0;
            if (num >= den) begin
              quo   <= ONE_N;
              state <= D_FIN;
            end else begin
              dv    <= ((den >> (WIDE - FRAC_BITS)) != '0) ? (den >> FRAC_BITS) : den;
              rem   <= n >> NIT;
              low   <= n << (WIDE - NIT);
              quo   <= '0;
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem <= qbit ? WIDE'(rem2 - {1'b0, dv}) : rem2[WIDE-1:0];
          low <= low << 1;
          quo <= {quo[NIT-2:0], qbit};
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NIT - 1)) begin
            state <= D_FIN;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/pps_front.sv =====
// Front end: configuration registers, item intake and kind classification,
// and a two-entry job queue toward the back end. Depends on pps_pkg.
module pps_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pps_pkg::pps_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [pps_pkg::MAG_WIDTH-1:0] cfg_data,
  output logic                          q_valid,
  input  logic                          q_pop,
  output pps_pkg::pps_job_t             q_job
);
  import pps_pkg::*;

  logic [2:0]           kind_cfg;
  logic [MAG_WIDTH-1:0] lam_cfg, shape_cfg;
  pps_job_t             slots [2];
  logic                 wr_ptr, rd_ptr;
  logic [1:0]           count;
  logic                 push;
  pps_job_t             job_next;

  always_comb begin
    in_stall = (count == 2'd2);
    push     = in_valid && !in_stall;
    q_valid  = (count != 2'd0);
    q_job    = slots[rd_ptr];
    job_next.item  = in_data;
    // Unused kind codes run as a plain step
    job_next.kind  = (kind_cfg > K_SCAD) ? K_NONE : kind_t'(kind_cfg);
    job_next.lam   = lam_cfg;
    job_next.shape = shape_cfg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_cfg  <= KIND_RESET;
      lam_cfg   <= LAMBDA_RESET;
      shape_cfg <= SHAPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND:   kind_cfg  <= cfg_data[2:0];
        CFG_LAMBDA: lam_cfg   <= cfg_data;
        CFG_SHAPE:  shape_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hdl/pps_back.sv =====
// Back end: a micro-sequenced datapath on a shared multiplier and divider,
// the penalty accumulator and the output register. Depends on pps_pkg,
// pps_mul and pps_div.
module pps_back #(
  parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  pps_pkg::pps_job_t q_job,
  output logic              out_valid,
  input  logic              out_stall,
  output pps_pkg::pps_out_t out_data
);
  import pps_pkg::*;

  localparam logic [WIDE-1:0] ONE_Q = WIDE'(1) << FRAC_BITS;
  localparam logic [WIDE:0]   LIM_P = {1'b0, LIM};
  localparam logic [WIDE:0]   LIM_N = (WIDE+1)'(0) - LIM_P;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_ALU, OP_END} op_t;
  typedef enum logic [3:0] {
    F_ADD, F_SUB, F_ADDC, F_SUBC, F_SOFT, F_HALF, F_MIN, F_SUBS,
    F_SHL1, F_SEL4, F_SEL5PP, F_OMQ5, F_SEL5P
  } fn_t;
  typedef enum logic [3:0] {
    S_X, S_D, S_W, S_TAU, S_LAM, S_A, S_T, S_ONE,
    S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7
  } src_t;
  typedef enum logic [2:0] {D_R0, D_R1, D_R2, D_R3, D_R4, D_R5, D_R6, D_R7} dst_t;
  typedef struct packed {
    op_t  op;
    fn_t  fn;
    src_t sa;
    src_t sb;
    dst_t dst;
  } uop_t;
  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;

  function automatic uop_t mk(op_t o, fn_t f, src_t a, src_t b, dst_t d);
    uop_t m;
    m.op = o; m.fn = f; m.sa = a; m.sb = b; m.dst = d;
    return m;
  endfunction

  function automatic uop_t mul(dst_t d, src_t a, src_t b);
    return mk(OP_MUL, F_ADD, a, b, d);
  endfunction

  function automatic uop_t div(dst_t d, src_t a, src_t b);
    return mk(OP_DIV, F_ADD, a, b, d);
  endfunction

  function automatic uop_t alu(fn_t f, dst_t d, src_t a, src_t b);
    return mk(OP_ALU, f, a, b, d);
  endfunction

  // Program for each penalty kind; r0 ends as the update, r1 as the penalty
  function automatic uop_t decode(kind_t k, logic [4:0] pc);
    uop_t fin;
    fin = mk(OP_END, F_ADD, S_ONE, S_ONE, D_R0);
    unique case (k)
      K_L1: begin
        unique case (pc)
          5'd0:    return mul(D_R2, S_LAM, S_TAU);
          5'd1:    return mul(D_R3, S_R2, S_W);
          5'd2:    return mul(D_R2, S_D, S_TAU);
          5'd3:    return alu(F_ADDC, D_R4, S_X, S_R2);
          5'd4:    return alu(F_SOFT, D_R0, S_R4, S_R3);
          5'd5:    return mul(D_R2, S_T, S_W);
          5'd6:    return mul(D_R1, S_LAM, S_R2);
          default: return fin;
        endcase
      end
      K_L2: begin
        unique case (pc)
          5'd0:    return mul(D_R2, S_X, S_LAM);
          5'd1:    return mul(D_R3, S_R2, S_W);
          5'd2:    return alu(F_SUBC, D_R4, S_R3, S_D);
          5'd3:    return mul(D_R5, S_R4, S_TAU);
          5'd4:    return alu(F_SUBC, D_R0, S_X, S_R5);
          5'd5:    return mul(D_R2, S_T, S_T);
          5'd6:    return mul(D_R3, S_R2, S_W);
          5'd7:    return mul(D_R4, S_LAM, S_R3);
          5'd8:    return alu(F_HALF, D_R1, S_R4, S_ONE);
          default: return fin;
        endcase
      end
      K_ELNET: begin
        unique case (pc)
          5'd0:    return alu(F_MIN, D_R6, S_A, S_ONE);
          5'd1:    return alu(F_SUB, D_R7, S_ONE, S_R6);
          5'd2:    return mul(D_R2, S_LAM, S_R7);
          5'd3:    return mul(D_R3, S_X, S_W);
          5'd4:    return mul(D_R4, S_R3, S_R2);
          5'd5:    return alu(F_SUBC, D_R5, S_D, S_R4);
          5'd6:    return mul(D_R2, S_R5, S_TAU);
          5'd7:    return alu(F_ADDC, D_R4, S_X, S_R2);
          5'd8:    return mul(D_R2, S_LAM, S_R6);
          5'd9:    return mul(D_R3, S_R2, S_TAU);
          5'd10:   return mul(D_R5, S_R3, S_W);
          5'd11:   return alu(F_SOFT, D_R0, S_R4, S_R5);
          5'd12:   return mul(D_R2, S_R6, S_T);
          5'd13:   return mul(D_R3, S_T, S_T);
          5'd14:   return mul(D_R4, S_R7, S_R3);
          5'd15:   return alu(F_HALF, D_R5, S_R4, S_ONE);
          5'd16:   return alu(F_ADD, D_R3, S_R2, S_R5);
          5'd17:   return mul(D_R2, S_R3, S_W);
          5'd18:   return mul(D_R1, S_LAM, S_R2);
          default: return fin;
        endcase
      end
      K_MCP: begin
        unique case (pc)
          5'd0:    return mul(D_R6, S_A, S_LAM);
          5'd1:    return div(D_R7, S_T, S_R6);
          5'd2:    return alu(F_SUB, D_R2, S_ONE, S_R7);
          5'd3:    return mul(D_R3, S_LAM, S_TAU);
          5'd4:    return mul(D_R4, S_R3, S_W);
          5'd5:    return mul(D_R5, S_R4, S_R2);
          5'd6:    return mul(D_R2, S_D, S_TAU);
          5'd7:    return alu(F_ADDC, D_R3, S_X, S_R2);
          5'd8:    return alu(F_SOFT, D_R0, S_R3, S_R5);
          5'd9:    return mul(D_R2, S_T, S_R7);
          5'd10:   return alu(F_HALF, D_R3, S_R2, S_ONE);
          5'd11:   return alu(F_SUB, D_R4, S_T, S_R3);
          5'd12:   return alu(F_SEL4, D_R5, S_R6, S_R4);
          5'd13:   return mul(D_R2, S_R5, S_W);
          5'd14:   return mul(D_R1, S_LAM, S_R2);
          default: return fin;
        endcase
      end
      K_SCAD: begin
        unique case (pc)
          5'd0:    return mul(D_R6, S_A, S_LAM);
          5'd1:    return alu(F_SUBS, D_R2, S_A, S_ONE);
          5'd2:    return mul(D_R7, S_LAM, S_R2);
          5'd3:    return alu(F_SUBS, D_R2, S_R6, S_T);
          5'd4:    return div(D_R3, S_R2, S_R7);
          5'd5:    return alu(F_SEL5PP, D_R4, S_R3, S_ONE);
          5'd6:    return mul(D_R2, S_LAM, S_TAU);
          5'd7:    return mul(D_R3, S_R2, S_W);
          5'd8:    return mul(D_R5, S_R3, S_R4);
          5'd9:    return mul(D_R2, S_D, S_TAU);
          5'd10:   return alu(F_ADDC, D_R3, S_X, S_R2);
          5'd11:   return alu(F_SOFT, D_R0, S_R3, S_R5);
          5'd12:   return alu(F_SUBS, D_R2, S_T, S_LAM);
          5'd13:   return alu(F_SHL1, D_R3, S_R7, S_ONE);
          5'd14:   return div(D_R4, S_R2, S_R3);
          5'd15:   return alu(F_OMQ5, D_R5, S_R4, S_ONE);
          5'd16:   return mul(D_R3, S_R2, S_R5);
          5'd17:   return alu(F_ADD, D_R4, S_LAM, S_R3);
          5'd18:   return alu(F_SEL5P, D_R5, S_R4, S_ONE);
          5'd19:   return mul(D_R2, S_R5, S_W);
          5'd20:   return mul(D_R1, S_LAM, S_R2);
          default: return fin;
        endcase
      end
      default: begin
        unique case (pc)
          5'd0:    return mul(D_R2, S_D, S_TAU);
          5'd1:    return alu(F_ADDC, D_R0, S_X, S_R2);
          5'd2:    return alu(F_SUB, D_R1, S_ONE, S_ONE);
          default: return fin;
        endcase
      end
    endcase
  endfunction

  function automatic logic [WIDE-1:0] clampw(logic [WIDE:0] v);
    if ($signed(v) > $signed(LIM_P)) begin
      return LIM;
    end else if ($signed(v) < $signed(LIM_N)) begin
      return LIM_N[WIDE-1:0];
    end
    return v[WIDE-1:0];
  endfunction

  state_t          state;
  logic [4:0]      pc;
  kind_t           kind;
  logic [WIDE-1:0] xr, dr, wr, taur, lamr, ar, tr, lor, hir;
  logic            lastr;
  logic [WIDE-1:0] r0, r1, r2, r3, r4, r5, r6, r7;
  logic [SUM_WIDTH-1:0] acc;

  uop_t            uop;
  logic [WIDE-1:0] opa, opb, alu_res, wv, mag, px, pos_x;
  logic [WIDE:0]   sum65, dif65;
  logic            mul_start, div_start, mul_done, div_done, wen, out_free;
  logic [WIDE-1:0] mul_res, div_res, u_fin;
  logic [WIDE-1:0] pen_cap;
  logic [SUM_WIDTH:0] acc_sum;
  logic [SUM_WIDTH-1:0] acc_next;

  always_comb begin
    uop = decode(kind, pc);
    unique case (uop.sa)
      S_X:     opa = xr;
      S_D:     opa = dr;
      S_W:     opa = wr;
      S_TAU:   opa = taur;
      S_LAM:   opa = lamr;
      S_A:     opa = ar;
      S_T:     opa = tr;
      S_ONE:   opa = ONE_Q;
      S_R0:    opa = r0;
      S_R1:    opa = r1;
      S_R2:    opa = r2;
      S_R3:    opa = r3;
      S_R4:    opa = r4;
      S_R5:    opa = r5;
      S_R6:    opa = r6;
      default: opa = r7;
    endcase
    unique case (uop.sb)
      S_X:     opb = xr;
      S_D:     opb = dr;
      S_W:     opb = wr;
      S_TAU:   opb = taur;
      S_LAM:   opb = lamr;
      S_A:     opb = ar;
      S_T:     opb = tr;
      S_ONE:   opb = ONE_Q;
      S_R0:    opb = r0;
      S_R1:    opb = r1;
      S_R2:    opb = r2;
      S_R3:    opb = r3;
      S_R4:    opb = r4;
      S_R5:    opb = r5;
      S_R6:    opb = r6;
      default: opb = r7;
    endcase
  end

  always_comb begin
    sum65 = {opa[WIDE-1], opa} + {opb[WIDE-1], opb};
    dif65 = {opa[WIDE-1], opa} - {opb[WIDE-1], opb};
    mag   = opa[WIDE-1] ? (WIDE'(0) - opa) : opa;
    px    = mag - opb;
    unique case (uop.fn)
      F_ADD:  alu_res = sum65[WIDE-1:0];
      F_SUB:  alu_res = dif65[WIDE-1:0];
      F_ADDC: alu_res = clampw(sum65);
      F_SUBC: alu_res = clampw(dif65);
      // Soft threshold: shrink the magnitude toward zero, keep the sign
      F_SOFT: begin
        if (mag <= opb) begin
          alu_res = '0;
        end else begin
          alu_res = opa[WIDE-1] ? (WIDE'(0) - px) : px;
        end
      end
      F_HALF: alu_res = opa >> 1;
      F_MIN:  alu_res = (opa > opb) ? opb : opa;
      F_SUBS: alu_res = (opa > opb) ? (opa - opb) : '0;
      F_SHL1: alu_res = opa << 1;
      F_SEL4: begin
        if (opa == '0) begin
          alu_res = '0;
        end else if (tr > opa) begin
          alu_res = opa >> 1;
        end else begin
          alu_res = opb;
        end
      end
      F_SEL5PP: alu_res = (tr >= r6) ? '0 : opa;
      F_OMQ5:   alu_res = (r7 == '0) ? ONE_Q : (ONE_Q - opa);
      F_SEL5P: begin
        if (tr >= r6) begin
          alu_res = lamr + (r7 >> 1);
        end else if (tr >= lamr) begin
          alu_res = opa;
        end else begin
          alu_res = tr;
        end
      end
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    q_pop     = (state == S_IDLE) && q_valid;
    mul_start = (state == S_ISSUE) && (uop.op == OP_MUL);
    div_start = (state == S_ISSUE) && (uop.op == OP_DIV);
    wv        = (state == S_WAIT) ? ((uop.op == OP_MUL) ? mul_res : div_res) : alu_res;
    wen       = ((state == S_ISSUE) && (uop.op == OP_ALU)) ||
                ((state == S_WAIT) && (mul_done || div_done));
    out_free  = !out_valid || !out_stall;

    // Upper bound is tested first, so it wins on inverted bounds when r0 lies above it
    if ($signed(r0) > $signed(hir)) begin
      u_fin = hir;
    end else if ($signed(r0) < $signed(lor)) begin
      u_fin = lor;
    end else begin
      u_fin = r0;
    end
    pen_cap  = (r1 > WIDE'(SUM_MAX)) ? WIDE'(SUM_MAX) : r1;
    acc_sum  = {1'b0, acc} + pen_cap[SUM_WIDTH:0];
    acc_next = acc_sum[SUM_WIDTH] ? SUM_MAX : acc_sum[SUM_WIDTH-1:0];
    pos_x    = xr;
  end

  pps_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .res   (mul_res)
  );

  pps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (opa),
    .den   (opb),
    .done  (div_done),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (wen) begin
      unique case (uop.dst)
        D_R0:    r0 <= wv;
        D_R1:    r1 <= wv;
        D_R2:    r2 <= wv;
        D_R3:    r3 <= wv;
        D_R4:    r4 <= wv;
        D_R5:    r5 <= wv;
        D_R6:    r6 <= wv;
        default: r7 <= wv;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      kind      <= K_NONE;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the transferred result unless a new one replaces it this cycle
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            kind  <= q_job.kind;
            xr    <= WIDE'(q_job.item.position);
            dr    <= WIDE'(q_job.item.direction);
            wr    <= WIDE'(q_job.item.weight);
            lor   <= WIDE'(q_job.item.lower_bound);
            hir   <= WIDE'(q_job.item.upper_bound);
            taur  <= WIDE'(q_job.item.step);
            lamr  <= WIDE'(q_job.lam);
            ar    <= WIDE'(q_job.shape);
            tr    <= q_job.item.position[VALUE_WIDTH-1] ?
                     (WIDE'(0) - WIDE'(q_job.item.position)) : WIDE'(q_job.item.position);
            lastr <= q_job.item.last;
            pc    <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          unique case (uop.op)
            OP_MUL,
            OP_DIV:  state <= S_WAIT;
            OP_ALU:  pc    <= pc + 5'd1;
            default: state <= S_OUT;
          endcase
        end
        S_WAIT: begin
          if (mul_done || div_done) begin
            pc    <= pc + 5'd1;
            state <= S_ISSUE;
          end
        end
        default: begin
          // Hold the finished result until the output register frees up
          if (out_free) begin
            out_valid                  <= 1'b1;
            out_data.new_position      <= u_fin[VALUE_WIDTH-1:0];
            out_data.active            <= (pos_x != '0) || (u_fin != pos_x);
            out_data.penalty_sum       <= acc_next;
            out_data.end_of_vector     <= lastr;
            acc                        <= lastr ? '0 : acc_next;
            state                      <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/penalized_proximal_step.sv =====
// Penalized proximal step: one result per item, one item in work at a time.
// The time per item depends on the penalty kind (none, l1, l2, elastic net, MCP, SCAD)
// and is set by the shared multiplier and the divider; for MCP and SCAD it is shorter
// for each quotient that saturates at one.
// Synchronous reset clears queue, sequencer, accumulator and loads config defaults.
module penalized_proximal_step #(
  parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pps_pkg::pps_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pps_pkg::pps_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [pps_pkg::MAG_WIDTH-1:0] cfg_data
);
  import pps_pkg::*;

  logic     q_valid, q_pop;
  pps_job_t q_job;

  pps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (q_job)
  );

  pps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (q_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/penalized_proximal_step_test.sv =====
// Self-checking testbench for penalized_proximal_step: directed table, then random
// vectors over a sweep of penalty settings, compared against a fixed-point predictor.
// Depends on hdl/pps_pkg.sv and hdl/penalized_proximal_step.sv.
`timescale 1ns / 100ps

module penalized_proximal_step_test;
  import pps_pkg::*;

  localparam longint unsigned ONE_Q   = 64'd65536;
  localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint          WLIM    = (64'sd1 <<< 62) - 64'sd1;
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_WIDTH) - 64'd1;
  localparam logic [2:0]      K_RSVD6 = 3'd6;
  localparam logic [2:0]      K_RSVD7 = 3'd7;
  localparam logic [31:0]     VMAX    = 32'h7fff_ffff;
  localparam logic [31:0]     VMIN    = 32'h8000_0000;
  localparam int              NPHASE  = 14;
  localparam int              PER_PHASE = 80;
  localparam int              LIMIT   = 1500000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pps_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pps_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_KIND;
  logic [MAG_WIDTH-1:0] cfg_data = '0;

  // Mirror of the block's state and registers
  longint unsigned pen_acc;
  logic [2:0]      m_kind;
  longint unsigned m_lam, m_shape;

  pps_out_t pending[$];
  int errors = 0, n_items = 0, n_results = 0, n_vectors = 0;
  int cycles = 0, idle_mode = 0;

  // Phase settings: kind, lambda, a
  logic [2:0] ph_kind [NPHASE] = '{K_NONE, K_L1, K_L2, K_ELNET, K_ELNET, K_MCP, K_MCP,
                                   K_SCAD, K_SCAD, K_RSVD6, K_RSVD7, K_L1, K_SCAD, K_MCP};
  logic [30:0] ph_lam [NPHASE] = '{31'd65536, 31'd3000, 31'd32768, 31'd20000, 31'd50000,
                                   31'd40000, 31'd0, 31'd30000, 31'd30000, 31'd65536,
                                   31'd65536, 31'h7fff_ffff, 31'd10000, 31'd0};
  logic [30:0] ph_a [NPHASE] = '{31'd196608, 31'd196608, 31'd0, 31'd32768, 31'd131072,
                                 31'd196608, 31'd196608, 31'd242483, 31'd32768, 31'd0,
                                 31'd65536, 31'd196608, 31'h7fff_ffff, 31'd0};

  always #5 clk = ~clk;

  penalized_proximal_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint clampw(longint v);
    if (v > WLIM) return WLIM;
    if (v < -WLIM) return -WLIM;
    return v;
  endfunction

  function automatic longint unsigned magof(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned umul(longint unsigned a, longint unsigned b);
    longint unsigned p;
    if (b != 0 && a > U64_MAX / b) return WLIM;
    p = (a * b) >> 16;
    return p > WLIM ? WLIM : p;
  endfunction

  function automatic longint smul(longint a, longint unsigned b);
    longint m;
    m = longint'(umul(magof(a), b));
    return a < 0 ? -m : m;
  endfunction

  // Quotient capped at one
  function automatic longint unsigned qdiv(longint unsigned t, longint unsigned u);
    if (t >= u) return ONE_Q;
    if (u > (U64_MAX >> 16)) return t / (u >> 16);
    return (t << 16) / u;
  endfunction

  function automatic longint shrink(longint z, longint unsigned thr);
    longint unsigned m;
    m = magof(z);
    if (m <= thr) return 0;
    m = m - thr;
    return z < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Proximal update and running penalty for one element; advances pen_acc
  function automatic pps_out_t step_predict(pps_in_t it);
    longint x, d, lo, hi, u, dd;
    longint unsigned w, tau, lam, a, t, lwt, pen, p, al, den, pp, ae, b, s, q;
    pps_out_t r;
    x = longint'($signed(it.position));
    d = longint'($signed(it.direction));
    lo = longint'($signed(it.lower_bound));
    hi = longint'($signed(it.upper_bound));
    w = 64'(it.weight);
    tau = 64'(it.step);
    lam = m_lam;
    a = m_shape;
    t = magof(x);
    lwt = umul(umul(lam, tau), w);
    pen = 0;
    case (m_kind)
      K_L1: begin
        u = shrink(clampw(x + smul(d, tau)), lwt);
        pen = umul(lam, umul(t, w));
      end
      K_L2: begin
        u = clampw(smul(smul(x, lam), w) - d);
        u = clampw(x - smul(u, tau));
        pen = umul(lam, umul(umul(t, t), w)) >> 1;
      end
      K_ELNET: begin
        ae = a > ONE_Q ? ONE_Q : a;
        b = ONE_Q - ae;
        dd = clampw(d - smul(smul(x, w), umul(lam, b)));
        u = shrink(clampw(x + smul(dd, tau)), umul(umul(umul(lam, ae), tau), w));
        p = umul(ae, t) + (umul(b, umul(t, t)) >> 1);
        pen = umul(lam, umul(p, w));
      end
      K_MCP: begin
        al = umul(a, lam);
        pp = (t >= al) ? 64'd0 : ONE_Q - qdiv(t, al);
        u = shrink(clampw(x + smul(d, tau)), umul(lwt, pp));
        if (al == 0) p = 0;
        else if (t > al) p = al >> 1;
        else p = t - (umul(t, qdiv(t, al)) >> 1);
        pen = umul(lam, umul(p, w));
      end
      K_SCAD: begin
        al = umul(a, lam);
        den = a > ONE_Q ? umul(lam, a - ONE_Q) : 64'd0;
        if (t >= al) pp = 0;
        else if (den == 0) pp = ONE_Q;
        else pp = qdiv(al - t, den);
        u = shrink(clampw(x + smul(d, tau)), umul(lwt, pp));
        if (t >= al) begin
          p = lam + (den >> 1);
        end else if (t >= lam) begin
          s = t - lam;
          q = den == 0 ? 64'd0 : qdiv(s, den << 1);
          p = lam + umul(s, ONE_Q - q);
        end else begin
          p = t;
        end
        pen = umul(lam, umul(p, w));
      end
      default: u = clampw(x + smul(d, tau));
    endcase
    // upper test wins on inverted bounds
    if (u > hi) u = hi;
    else if (u < lo) u = lo;
    if (u > 64'sd2147483647) u = 64'sd2147483647;
    if (u < -64'sd2147483648) u = -64'sd2147483648;
    if (pen > SUM_MAX) pen = SUM_MAX;
    pen_acc = pen_acc + pen;
    if (pen_acc > SUM_MAX) pen_acc = SUM_MAX;
    r.new_position = u[31:0];
    r.active = (x != 0 || u != x);
    r.penalty_sum = pen_acc[SUM_WIDTH-1:0];
    r.end_of_vector = it.last;
    if (it.last) pen_acc = 0;
    return r;
  endfunction

  function automatic pps_in_t mk(logic [31:0] x, logic [31:0] d, logic [30:0] w,
                                 logic [31:0] lo, logic [31:0] hi, logic [30:0] st,
                                 logic last);
    pps_in_t it;
    it.position = x; it.direction = d; it.weight = w;
    it.lower_bound = lo; it.upper_bound = hi; it.step = st; it.last = last;
    return it;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return VMAX;
      2: return VMIN;
      3, 4, 5: return $urandom_range(0, 1) ? $urandom_range(0, 32'h40000)
                                           : -$urandom_range(0, 32'h40000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_mag(logic [30:0] common);
    case ($urandom_range(0, 7))
      0: return 31'd0;
      1: return 31'h7fff_ffff;
      2, 3: return common;
      4, 5: return 31'($urandom_range(0, 32'h20000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic pps_in_t rand_item();
    pps_in_t it;
    logic [31:0] v1, v2;
    it.position = rand_val();
    it.direction = rand_val();
    it.weight = rand_mag(31'd65536);
    it.step = rand_mag(31'd16384);
    v1 = rand_val();
    v2 = rand_val();
    case ($urandom_range(0, 5))
      0: begin it.lower_bound = VMIN; it.upper_bound = VMAX; end
      1: begin it.lower_bound = v1; it.upper_bound = v2; end
      default: begin
        it.lower_bound = ($signed(v1) < $signed(v2)) ? v1 : v2;
        it.upper_bound = ($signed(v1) < $signed(v2)) ? v2 : v1;
      end
    endcase
    it.last = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s at result %0d: got %0d, want %0d", what, n_results, got, want);
    errors++;
  endtask

  task automatic send_item(pps_in_t it, bit typed, pps_out_t typed_res);
    pps_out_t r;
    bit st;
    int gap;
    gap = idle_mode == 0 ? 27 : idle_mode == 1 ? 74 : 0;
    while ($urandom_range(0, 99) < gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    r = step_predict(it);
    pending.push_back(typed ? typed_res : r);
    n_items++;
    if (it.last) n_vectors++;
    if (n_items == 370) idle_mode = 1;
    if (n_items == 740) idle_mode = 2;
  endtask

  // Hold the sender until every expected transfer is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [30:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      CFG_KIND:   m_kind = v[2:0];
      CFG_LAMBDA: m_lam = 64'(v);
      default:    m_shape = 64'(v);
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL penalized_proximal_step");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (idle_mode)
      0: out_stall <= ($urandom_range(0, 99) < 74);
      1: out_stall <= ($urandom_range(0, 99) < 27);
      default: out_stall <= 1'b0;
    endcase
  end

  always @(negedge clk) begin
    pps_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        report("unexpected transfer", out_data.new_position, 0);
      end else begin
        e = pending.pop_front();
        if (out_data.new_position !== e.new_position)
          report("new_position", $signed(out_data.new_position), $signed(e.new_position));
        if (out_data.active !== e.active)
          report("active", out_data.active, e.active);
        if (out_data.penalty_sum !== e.penalty_sum)
          report("penalty_sum", out_data.penalty_sum, e.penalty_sum);
        if (out_data.end_of_vector !== e.end_of_vector)
          report("end_of_vector", out_data.end_of_vector, e.end_of_vector);
      end
      n_results++;
    end
  end

  initial begin
    typedef struct {
      pps_in_t  it;
      bit       typed;
      pps_out_t res;
    } row_t;
    row_t rows[$];
    row_t rw;
    pps_out_t none;
    none = '0;
    pen_acc = 0;
    m_kind = KIND_RESET;
    m_lam = 64'(LAMBDA_RESET);
    m_shape = 64'(SHAPE_RESET);

    // Reset settings: l1, lambda 1.0, a 3.0
    rw.typed = 1;
    rw.it = mk(0, 0, 0, VMIN, VMAX, 0, 0);
    rw.res = '{32'd0, 1'b0, 47'd0, 1'b0};
    rows.push_back(rw);
    rw.it = mk(32'd65536, 0, 31'd65536, VMIN, VMAX, 0, 0);
    rw.res = '{32'd65536, 1'b1, 47'd65536, 1'b0};
    rows.push_back(rw);
    // inverted bounds: upper wins
    rw.it = mk(0, 0, 0, 32'd131072, -32'sd131072, 0, 1);
    rw.res = '{-32'sd131072, 1'b1, 47'd65536, 1'b1};
    rows.push_back(rw);
    rw.typed = 0;
    rw.res = none;
    rw.it = mk(VMAX, VMAX, 31'h7fff_ffff, VMIN, VMAX, 31'h7fff_ffff, 0);  rows.push_back(rw);
    rw.it = mk(VMIN, VMIN, 31'h7fff_ffff, VMIN, VMAX, 31'h7fff_ffff, 0);  rows.push_back(rw);
    rw.it = mk(VMIN, VMAX, 31'h7fff_ffff, VMIN, VMAX, 31'd65536, 1);      rows.push_back(rw);
    rw.it = mk(32'd100000, -32'sd50000, 31'd65536, -32'sd10, 32'd10, 31'd32768, 0);
    rows.push_back(rw);
    rw.it = mk(-32'sd70000, 32'd1000, 31'd131072, VMIN, VMAX, 31'd1, 0);  rows.push_back(rw);
    rw.it = mk(32'd1, 32'd1, 31'd1, 32'd0, 32'd0, 31'd1, 1);              rows.push_back(rw);
    // drive the sum into saturation
    rw.it = mk(VMIN, 0, 31'h7fff_ffff, VMIN, VMAX, 0, 0);                 rows.push_back(rw);
    rw.it = mk(VMIN, 0, 31'h7fff_ffff, VMIN, VMAX, 0, 0);                 rows.push_back(rw);
    rw.it = mk(VMAX, 0, 31'h7fff_ffff, VMIN, VMAX, 0, 0);                 rows.push_back(rw);
    rw.it = mk(0, 32'd65536, 31'd65536, VMIN, VMAX, 31'd65536, 1);       rows.push_back(rw);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

    for (int ph = 0; ph < NPHASE; ph++) begin
      drain();
      write_reg(CFG_KIND, {28'd0, ph_kind[ph]});
      write_reg(CFG_LAMBDA, ph_lam[ph]);
      write_reg(CFG_SHAPE, ph_a[ph]);
      cfg_we <= 1'b0;
      for (int k = 0; k < PER_PHASE; k++) begin
        send_item(rand_item(), 0, none);
        // close a vector just before the last random item of each phase
        if (k == PER_PHASE - 2) send_item(mk(rand_val(), rand_val(), 31'd65536,
                                             VMIN, VMAX, 31'd4096, 1), 0, none);
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d elements in %0d vectors, %0d results, %0d penalty settings",
             n_items, n_vectors, n_results, NPHASE + 1);
    $display("mismatches: %0d", errors);
    if (errors == 0 && pending.size() == 0) begin
      $display("PASS penalized_proximal_step");
    end else begin
      $display("FAIL penalized_proximal_step");
    end
    $finish;
  end

endmodule
